### hdl/smpf_pkg.sv
// ----------------------------------------------------------------------------
// smpf_pkg
// Shared types and constants of the sliding median pupil filter.
// ----------------------------------------------------------------------------
package smpf_pkg;

  localparam int SMPF_WINDOW_MAX = 32;   // default window depth
  localparam int DW              = 16;   // Q12.4 sample width
  localparam int NCH             = 3;    // x, y, diameter
  localparam int CFG_W           = 6;    // window_length register width
  localparam logic [CFG_W-1:0] LEN_RESET = CFG_W'(5);

  // channel lanes inside a sample vector
  localparam int CH_X = 0;
  localparam int CH_Y = 1;
  localparam int CH_D = 2;

  typedef logic [NCH-1:0][DW-1:0] smpf_vec_t;

  // control broadcast to every cell of the window chain
  typedef struct packed {
    logic load;   // take a new item: shift or fill, seed probe, clear ranks
    logic fill;   // write the item into every cell
    logic step;   // one ranking step: compare broadcast, advance probe
  } smpf_ctrl_t;

endpackage

### hdl/smpf_if.sv
// ----------------------------------------------------------------------------
// smpf_if
// Valid/ready channels of the sliding median pupil filter.
// ----------------------------------------------------------------------------
interface smpf_in_if;
  logic        valid;
  logic        ready;
  logic [15:0] center_x;
  logic [15:0] center_y;
  logic [15:0] diameter;
  logic        restart;
  modport source (output valid, center_x, center_y, diameter, restart, input ready);
  modport sink   (input valid, center_x, center_y, diameter, restart, output ready);
endinterface

interface smpf_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] median_x;
  logic [15:0] median_y;
  logic [15:0] median_diameter;
  modport source (output valid, median_x, median_y, median_diameter, input ready);
  modport sink   (input valid, median_x, median_y, median_diameter, output ready);
endinterface

interface smpf_cfg_if;
  logic       valid;
  logic       ready;
  logic [5:0] window_length;
  modport source (output valid, window_length, input ready);
  modport sink   (input valid, window_length, output ready);
endinterface

### hdl/smpf_cell.sv
// ----------------------------------------------------------------------------
// smpf_cell
// One window slot: holds a sample of each channel, a probe copy that walks
// toward slot 0, and a rank counter per channel.
// ----------------------------------------------------------------------------
module smpf_cell
  import smpf_pkg::*;
#(
  parameter int IW  = 5,
  parameter int IDX = 0
) (
  input  logic                    clk,
  input  smpf_ctrl_t              ctrl,
  input  smpf_vec_t               sample,
  input  smpf_vec_t               left_win,
  input  smpf_vec_t               right_probe,
  input  smpf_vec_t               bcast,
  input  logic [IW-1:0]           step_idx,
  output smpf_vec_t               win,
  output smpf_vec_t               probe,
  output logic [NCH-1:0][IW-1:0]  rank
);

  localparam logic [IW-1:0] MY_IDX = IW'(IDX);

  smpf_vec_t              win_r, win_nxt;
  smpf_vec_t              probe_r, probe_nxt;
  logic [NCH-1:0][IW-1:0] rank_r, rank_nxt;
  smpf_vec_t              shift_in;

  always_comb begin
    shift_in  = ctrl.fill ? sample : left_win;
    win_nxt   = win_r;
    probe_nxt = probe_r;
    rank_nxt  = rank_r;
    if (ctrl.load) begin
      win_nxt   = shift_in;
      probe_nxt = shift_in;
      rank_nxt  = '0;
    end else if (ctrl.step) begin
      probe_nxt = right_probe;
      // count entries ranked below this one; break ties by slot order
      for (int c = 0; c < NCH; c++) begin
        if ((bcast[c] < win_r[c]) || ((bcast[c] == win_r[c]) && (step_idx < MY_IDX))) begin
          rank_nxt[c] = rank_r[c] + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    win_r   <= win_nxt;
    probe_r <= probe_nxt;
    rank_r  <= rank_nxt;
  end

  assign win   = win_r;
  assign probe = probe_r;
  assign rank  = rank_r;

endmodule

### hdl/smpf_select.sv
// ----------------------------------------------------------------------------
// smpf_select
// Picks the two middle ranked entries of each channel and averages them.
// ----------------------------------------------------------------------------
module smpf_select
  import smpf_pkg::*;
#(
  parameter int WINDOW_MAX = SMPF_WINDOW_MAX,
  parameter int IW         = 5
) (
  input  logic                   clk,
  input  logic                   capture,
  input  smpf_vec_t              vals  [WINDOW_MAX],
  input  logic [NCH-1:0][IW-1:0] ranks [WINDOW_MAX],
  input  logic [WINDOW_MAX-1:0]  active,
  input  logic [IW-1:0]          k_lo,
  input  logic [IW-1:0]          k_hi,
  output smpf_vec_t              median
);

  smpf_vec_t lo_r, lo_nxt;
  smpf_vec_t hi_r, hi_nxt;
  smpf_vec_t lo_or, hi_or;

  // ranks of active slots are unique, so an OR tree selects exactly one
  always_comb begin
    lo_or = '0;
    hi_or = '0;
    for (int i = 0; i < WINDOW_MAX; i++) begin
      for (int c = 0; c < NCH; c++) begin
        if (active[i] && (ranks[i][c] == k_lo)) lo_or[c] = lo_or[c] | vals[i][c];
        if (active[i] && (ranks[i][c] == k_hi)) hi_or[c] = hi_or[c] | vals[i][c];
      end
    end
    lo_nxt = capture ? lo_or : lo_r;
    hi_nxt = capture ? hi_or : hi_r;
  end

  always_ff @(posedge clk) begin
    lo_r <= lo_nxt;
    hi_r <= hi_nxt;
  end

  always_comb begin
    logic [DW:0] sum;
    for (int c = 0; c < NCH; c++) begin
      sum       = {1'b0, lo_r[c]} + {1'b0, hi_r[c]};
      median[c] = sum[DW:1];
    end
  end

endmodule

### hdl/sliding_median_pupil_filter_core.sv
// ----------------------------------------------------------------------------
// sliding_median_pupil_filter_core
// Per-channel sliding window median of pupil center x, y and diameter.
// ----------------------------------------------------------------------------
// Usage:
//   in_item  : one pupil measurement per item (center_x, center_y, diameter,
//              unsigned Q12.4, plus restart). restart, or the first item
//              after reset or a window_length write, fills the whole window.
//   out_item : one result item per input item, the three medians. An even
//              window gives the floor of the mean of the two middle values.
//   cfg_wr   : writes window_length (0 acts as 1, above WINDOW_MAX acts as
//              WINDOW_MAX) and empties the window. Always ready; write only
//              while no item is in flight.
// Flow: with n the active window length, an item is ranked by the cell
//   chain in ST_RANK, one probe entry per cycle walking to slot 0 and being
//   compared in every cell until all n entries are broadcast; ST_PICK then
//   captures the two middle entries and ST_SEND averages them into the output
//   register. The next item is taken only after ST_SEND, back in ST_IDLE.
// Reset: window marked empty, window_length back to 5, output empty.
// Stall: a finished result waits in the output register; a new item is still
//   accepted, and its result waits in the last stage until the register frees.
module sliding_median_pupil_filter_core
  import smpf_pkg::*;
#(
  parameter int WINDOW_MAX = SMPF_WINDOW_MAX
) (
  input  logic        clk,
  input  logic        rst_n,
  smpf_in_if.sink     in_item,
  smpf_out_if.source  out_item,
  smpf_cfg_if.sink    cfg_wr
);

  localparam int IW = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;   // slot index
  localparam int CW = $clog2(WINDOW_MAX + 1);                        // length
  localparam int LW = (CW > CFG_W) ? CW : CFG_W;                     // compare width

  typedef enum logic [1:0] {ST_IDLE, ST_RANK, ST_PICK, ST_SEND} state_t;

  state_t           state_r, state_nxt;
  logic [CFG_W-1:0] len_r, len_nxt;
  logic             filled_r, filled_nxt;
  logic [IW-1:0]    step_r, step_nxt;
  logic             out_valid_r, out_valid_nxt;
  smpf_vec_t        out_r, out_nxt;

  logic             in_acc;
  logic             cfg_acc;
  logic [LW-1:0]    len_ext;
  logic [CW-1:0]    n_act;
  logic [IW-1:0]    n_last;
  logic [IW-1:0]    k_lo, k_hi;
  smpf_ctrl_t       ctrl;
  smpf_vec_t        sample;
  smpf_vec_t        median;
  logic [WINDOW_MAX-1:0] active;

  smpf_vec_t              cell_win   [WINDOW_MAX];
  smpf_vec_t              cell_probe [WINDOW_MAX];
  logic [NCH-1:0][IW-1:0] cell_rank  [WINDOW_MAX];

  assign in_acc  = in_item.valid & in_item.ready;
  assign cfg_acc = cfg_wr.valid & cfg_wr.ready;

  assign in_item.ready = (state_r == ST_IDLE);
  assign cfg_wr.ready  = 1'b1;

  // clamp the register into 1..WINDOW_MAX
  always_comb begin
    len_ext = LW'(len_r);
    if (len_ext == '0) begin
      n_act = CW'(1);
    end else if (len_ext > LW'(WINDOW_MAX)) begin
      n_act = CW'(WINDOW_MAX);
    end else begin
      n_act = CW'(len_ext);
    end
  end

  // middle ranks: equal for odd n, adjacent for even n
  assign n_last = IW'(n_act - CW'(1));
  assign k_hi   = IW'(n_act >> 1);
  assign k_lo   = n_act[0] ? k_hi : (k_hi - IW'(1));

  assign sample[CH_X] = in_item.center_x;
  assign sample[CH_Y] = in_item.center_y;
  assign sample[CH_D] = in_item.diameter;

  assign ctrl.load = in_acc;
  assign ctrl.fill = in_item.restart | ~filled_r;
  assign ctrl.step = (state_r == ST_RANK);

  // Window chain: slot 0 takes the new item, every other slot its left
  // neighbor; the probe copies walk right to left into slot 0, which
  // broadcasts one entry per ranking step.
  for (genvar i = 0; i < WINDOW_MAX; i++) begin : g_cell
    smpf_vec_t left_win;
    smpf_vec_t right_probe;

    if (i == 0) begin : g_head
      assign left_win = sample;
    end else begin : g_body
      assign left_win = cell_win[i-1];
    end

    if (i == WINDOW_MAX - 1) begin : g_tail
      assign right_probe = '0;
    end else begin : g_mid
      assign right_probe = cell_probe[i+1];
    end

    assign active[i] = (CW'(i) < n_act);

    smpf_cell #(
      .IW  (IW),
      .IDX (i)
    ) u_cell (
      .clk         (clk),
      .ctrl        (ctrl),
      .sample      (sample),
      .left_win    (left_win),
      .right_probe (right_probe),
      .bcast       (cell_probe[0]),
      .step_idx    (step_r),
      .win         (cell_win[i]),
      .probe       (cell_probe[i]),
      .rank        (cell_rank[i])
    );
  end

  smpf_select #(
    .WINDOW_MAX (WINDOW_MAX),
    .IW         (IW)
  ) u_select (
    .clk     (clk),
    .capture (state_r == ST_PICK),
    .vals    (cell_win),
    .ranks   (cell_rank),
    .active  (active),
    .k_lo    (k_lo),
    .k_hi    (k_hi),
    .median  (median)
  );

  always_comb begin
    state_nxt     = state_r;
    len_nxt       = len_r;
    filled_nxt    = filled_r;
    step_nxt      = step_r;
    out_valid_nxt = out_valid_r;
    out_nxt       = out_r;

    // drop the result once taken
    if (out_valid_r && out_item.ready) out_valid_nxt = 1'b0;

    case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          filled_nxt = 1'b1;
          step_nxt   = '0;
          state_nxt  = ST_RANK;
        end
      end
      ST_RANK: begin
        step_nxt = step_r + IW'(1);
        if (step_r == n_last) state_nxt = ST_PICK;
      end
      ST_PICK: begin
        state_nxt = ST_SEND;
      end
      ST_SEND: begin
        // hold until the output register is free
        if (!out_valid_r || out_item.ready) begin
          out_valid_nxt = 1'b1;
          out_nxt       = median;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase

    if (cfg_acc) begin
      len_nxt    = cfg_wr.window_length;
      filled_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      len_r       <= LEN_RESET;
      filled_r    <= 1'b0;
      step_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      len_r       <= len_nxt;
      filled_r    <= filled_nxt;
      step_r      <= step_nxt;
      out_valid_r <= out_valid_nxt;
    end
    out_r <= out_nxt;
  end

  assign out_item.valid           = out_valid_r;
  assign out_item.median_x        = out_r[CH_X];
  assign out_item.median_y        = out_r[CH_Y];
  assign out_item.median_diameter = out_r[CH_D];

endmodule

### hdl/smpf_checker.sv
// ----------------------------------------------------------------------------
// smpf_checker
// Port-level checks of the sliding median pupil filter, bound to the core.
// ----------------------------------------------------------------------------
module smpf_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [15:0] median_x,
  input logic [15:0] median_y,
  input logic [15:0] median_diameter
);

  // a stalled result holds its value
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(median_x) && $stable(median_y)
      && $stable(median_diameter))
    else $error("result changed or vanished while stalled");

  // reset empties the output
  a_rst_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  // one item in flight: the block is busy right after an accept
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("second item accepted while ranking");

  // ranking lies between accept and result, so no result appears right after an accept
  a_no_early: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !$rose(out_valid))
    else $error("result appeared one cycle after accept");

endmodule

bind sliding_median_pupil_filter_core smpf_checker u_smpf_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_valid        (in_item.valid),
  .in_ready        (in_item.ready),
  .out_valid       (out_item.valid),
  .out_ready       (out_item.ready),
  .median_x        (out_item.median_x),
  .median_y        (out_item.median_y),
  .median_diameter (out_item.median_diameter)
);
